[rtl/dspq_pkg.sv]
// ----------------------------------------------------------------------------
// dspq_pkg
// Shared codes for the distance-sorted priority queue: opcodes, result status,
// cell commands and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dspq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } cell_cmd_t;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GOAL_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GOAL_Y = 2'd1;

endpackage

`default_nettype wire

[rtl/dspq_if.sv]
// ----------------------------------------------------------------------------
// dspq channel interfaces
// Request, response and configuration channels of the priority queue, each a
// valid/ready channel with its payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface dspq_req_if #(
    parameter int COORD_BITS = 10
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            opcode;
    logic [COORD_BITS-1:0] cell_x;
    logic [COORD_BITS-1:0] cell_y;

    modport source (output valid, output opcode, output cell_x, output cell_y,
                    input ready);
    modport sink   (input valid, input opcode, input cell_x, input cell_y,
                    output ready);
endinterface

interface dspq_rsp_if #(
    parameter int COORD_BITS = 10,
    parameter int OCC_BITS   = 7
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [COORD_BITS-1:0]   head_x;
    logic [COORD_BITS-1:0]   head_y;
    logic [2*COORD_BITS:0]   head_key;
    logic [OCC_BITS-1:0]     occupancy;

    modport source (output valid, output status, output head_x, output head_y,
                    output head_key, output occupancy, input ready);
    modport sink   (input valid, input status, input head_x, input head_y,
                    input head_key, input occupancy, output ready);
endinterface

interface dspq_cfg_if #(
    parameter int COORD_BITS = 10
);
    logic                                  valid;
    logic                                  ready;
    logic [dspq_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [COORD_BITS-1:0]                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/dspq_key_calc.sv]
// ----------------------------------------------------------------------------
// dspq_key_calc
// Two-stage elastic pipeline computing the squared distance of a cell to the
// goal: absolute differences and squares, then the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module dspq_key_calc #(
    parameter int COORD_BITS = 10,
    parameter int KEY_BITS   = 21
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            in_opcode,
    input  wire logic [COORD_BITS-1:0] in_x,
    input  wire logic [COORD_BITS-1:0] in_y,
    input  wire logic [COORD_BITS-1:0] goal_x,
    input  wire logic [COORD_BITS-1:0] goal_y,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_opcode,
    output logic [COORD_BITS-1:0]      out_x,
    output logic [COORD_BITS-1:0]      out_y,
    output logic [KEY_BITS-1:0]        out_key
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [1:0]            s1_op_reg;
    logic [COORD_BITS-1:0] s1_x_reg;
    logic [COORD_BITS-1:0] s1_y_reg;
    logic [SQ_BITS-1:0]    s1_sqx_reg;
    logic [SQ_BITS-1:0]    s1_sqy_reg;

    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    logic [1:0]            s2_op_reg;
    logic [COORD_BITS-1:0] s2_x_reg;
    logic [COORD_BITS-1:0] s2_y_reg;
    logic [KEY_BITS-1:0]   s2_key_reg;

    logic                  s1_load;
    logic                  s2_load;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [SQ_BITS-1:0]    sqx;
    logic [SQ_BITS-1:0]    sqy;

    assign s2_load  = !s2_valid_reg || out_ready;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        dx  = (in_x >= goal_x) ? (in_x - goal_x) : (goal_x - in_x);
        dy  = (in_y >= goal_y) ? (in_y - goal_y) : (goal_y - in_y);
        sqx = {{COORD_BITS{1'b0}}, dx} * {{COORD_BITS{1'b0}}, dx};
        sqy = {{COORD_BITS{1'b0}}, dy} * {{COORD_BITS{1'b0}}, dy};
        s1_valid_next = s1_load ? in_valid : s1_valid_reg;
        s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_op_reg  <= in_opcode;
            s1_x_reg   <= in_x;
            s1_y_reg   <= in_y;
            s1_sqx_reg <= sqx;
            s1_sqy_reg <= sqy;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_x_reg   <= s1_x_reg;
            s2_y_reg   <= s1_y_reg;
            s2_key_reg <= KEY_BITS'({1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg});
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_opcode = s2_op_reg;
    assign out_x      = s2_x_reg;
    assign out_y      = s2_y_reg;
    assign out_key    = s2_key_reg;

endmodule

`default_nettype wire

[rtl/dspq_cell.sv]
// ----------------------------------------------------------------------------
// dspq_cell
// One slot of the sorted shift chain. Compares its key against the broadcast
// key and keeps, takes the new entry, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module dspq_cell #(
    parameter int COORD_BITS = 10,
    parameter int KEY_BITS   = 21
) (
    input  wire logic                  clk,
    input  wire dspq_pkg::cell_cmd_t   cmd,
    input  wire logic                  occupied,
    input  wire logic [COORD_BITS-1:0] new_x,
    input  wire logic [COORD_BITS-1:0] new_y,
    input  wire logic [KEY_BITS-1:0]   new_key,
    input  wire logic                  left_behind,
    input  wire logic [COORD_BITS-1:0] left_x,
    input  wire logic [COORD_BITS-1:0] left_y,
    input  wire logic [KEY_BITS-1:0]   left_key,
    input  wire logic [COORD_BITS-1:0] right_x,
    input  wire logic [COORD_BITS-1:0] right_y,
    input  wire logic [KEY_BITS-1:0]   right_key,
    output logic                       behind,
    output logic [COORD_BITS-1:0]      x,
    output logic [COORD_BITS-1:0]      y,
    output logic [KEY_BITS-1:0]        key
);

    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] x_next;
    logic [COORD_BITS-1:0] y_reg;
    logic [COORD_BITS-1:0] y_next;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;

    // The new entry lands ahead of equal keys, and empty slots count as behind.
    assign behind = !occupied || (key_reg >= new_key);

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        key_next = key_reg;
        unique case (cmd)
            dspq_pkg::CELL_HOLD:
            begin
                x_next   = x_reg;
            end
            dspq_pkg::CELL_INSERT:
            begin
                if (behind && left_behind)
                begin
                    x_next   = left_x;
                    y_next   = left_y;
                    key_next = left_key;
                end
                else if (behind)
                begin
                    x_next   = new_x;
                    y_next   = new_y;
                    key_next = new_key;
                end
            end
            dspq_pkg::CELL_POP:
            begin
                x_next   = right_x;
                y_next   = right_y;
                key_next = right_key;
            end
            default:
            begin
                x_next   = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        key_reg <= key_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign key = key_reg;

endmodule

`default_nettype wire

[rtl/distance_sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// distance_sorted_priority_queue_top
// Open-list priority queue ordered by squared distance to a goal cell.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  - write goal_x (index 0) or goal_y (index 1); always ready. Write
//          only while no request is in flight.
//   req  - one beat per operation: insert (cell_x, cell_y), pop, clear, nop.
//   rsp  - one beat per request, in order: status, popped head, occupancy.
// Path: a request passes the squares register, the sum register, then the
//   queue update into the response register.
// Throughput: one request per cycle while rsp is ready; all cells update at
//   once, so back-to-back inserts and pops never wait on each other.
// Stall: when rsp is held off, the response register holds its beat and the
//   key pipeline fills up; req.ready drops once every stage holds a beat.
// Reset: the queue is empty, goal is (0, 0) and the pipeline holds no beat.
//   Slot contents are not cleared; only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 64,
    parameter int COORD_BITS  = 10
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dspq_req_if.sink   req,
    dspq_rsp_if.source rsp,
    dspq_cfg_if.sink   cfg
);

    localparam int KEY_BITS = 2 * COORD_BITS + 1;
    localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [COORD_BITS-1:0] goal_x_reg;
    logic [COORD_BITS-1:0] goal_y_reg;

    logic                  kc_valid;
    logic                  kc_ready;
    logic [1:0]            kc_op;
    logic [COORD_BITS-1:0] kc_x;
    logic [COORD_BITS-1:0] kc_y;
    logic [KEY_BITS-1:0]   kc_key;

    logic [OCC_BITS-1:0]   count_reg;
    logic [OCC_BITS-1:0]   count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    dspq_pkg::status_t     status_reg;
    dspq_pkg::status_t     status_next;
    logic [COORD_BITS-1:0] head_x_reg;
    logic [COORD_BITS-1:0] head_x_next;
    logic [COORD_BITS-1:0] head_y_reg;
    logic [COORD_BITS-1:0] head_y_next;
    logic [KEY_BITS-1:0]   head_key_reg;
    logic [KEY_BITS-1:0]   head_key_next;
    logic [OCC_BITS-1:0]   occ_reg;

    logic                  go;
    logic                  full;
    logic                  empty;
    dspq_pkg::cell_cmd_t   cell_cmd;

    logic                  c_behind [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] c_x      [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] c_y      [QUEUE_DEPTH];
    logic [KEY_BITS-1:0]   c_key    [QUEUE_DEPTH];

    // Configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == dspq_pkg::REG_GOAL_X)
            begin
                goal_x_reg <= cfg.data;
            end
            if (cfg.index == dspq_pkg::REG_GOAL_Y)
            begin
                goal_y_reg <= cfg.data;
            end
        end
    end

    dspq_key_calc #(
        .COORD_BITS (COORD_BITS),
        .KEY_BITS   (KEY_BITS)
    ) u_key_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_opcode  (req.opcode),
        .in_x       (req.cell_x),
        .in_y       (req.cell_y),
        .goal_x     (goal_x_reg),
        .goal_y     (goal_y_reg),
        .out_valid  (kc_valid),
        .out_ready  (kc_ready),
        .out_opcode (kc_op),
        .out_x      (kc_x),
        .out_y      (kc_y),
        .out_key    (kc_key)
    );

    // Apply stage: advance when the response register is free or draining.
    assign kc_ready = !rsp_valid_reg || rsp.ready;
    assign go       = kc_valid && kc_ready;
    assign full     = (count_reg == OCC_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        cell_cmd      = dspq_pkg::CELL_HOLD;
        count_next    = count_reg;
        status_next   = dspq_pkg::ST_DONE;
        head_x_next   = '0;
        head_y_next   = '0;
        head_key_next = '0;
        if (go)
        begin
            unique case (dspq_pkg::opcode_t'(kc_op))
                dspq_pkg::OP_INSERT:
                begin
                    if (full)
                    begin
                        status_next = dspq_pkg::ST_FULL;
                    end
                    else
                    begin
                        cell_cmd   = dspq_pkg::CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                dspq_pkg::OP_POP:
                begin
                    if (empty)
                    begin
                        status_next = dspq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cell_cmd      = dspq_pkg::CELL_POP;
                        count_next    = count_reg - 1'b1;
                        head_x_next   = c_x[0];
                        head_y_next   = c_y[0];
                        head_key_next = c_key[0];
                    end
                end
                dspq_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                dspq_pkg::OP_NOP:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        rsp_valid_next = go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg   <= status_next;
            head_x_reg   <= head_x_next;
            head_y_reg   <= head_y_next;
            head_key_reg <= head_key_next;
            occ_reg      <= count_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.head_x    = head_x_reg;
    assign rsp.head_y    = head_y_reg;
    assign rsp.head_key  = head_key_reg;
    assign rsp.occupancy = occ_reg;

    // Cell chain, slot 0 is the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                  occupied;
        logic                  l_behind;
        logic [COORD_BITS-1:0] l_x;
        logic [COORD_BITS-1:0] l_y;
        logic [KEY_BITS-1:0]   l_key;
        logic [COORD_BITS-1:0] r_x;
        logic [COORD_BITS-1:0] r_y;
        logic [KEY_BITS-1:0]   r_key;

        assign occupied = (OCC_BITS'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign l_behind = 1'b0;
            assign l_x      = kc_x;
            assign l_y      = kc_y;
            assign l_key    = kc_key;
        end
        else
        begin : g_mid
            assign l_behind = c_behind[i-1];
            assign l_x      = c_x[i-1];
            assign l_y      = c_y[i-1];
            assign l_key    = c_key[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_x   = c_x[i];
            assign r_y   = c_y[i];
            assign r_key = c_key[i];
        end
        else
        begin : g_inner
            assign r_x   = c_x[i+1];
            assign r_y   = c_y[i+1];
            assign r_key = c_key[i+1];
        end

        dspq_cell #(
            .COORD_BITS (COORD_BITS),
            .KEY_BITS   (KEY_BITS)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .occupied    (occupied),
            .new_x       (kc_x),
            .new_y       (kc_y),
            .new_key     (kc_key),
            .left_behind (l_behind),
            .left_x      (l_x),
            .left_y      (l_y),
            .left_key    (l_key),
            .right_x     (r_x),
            .right_y     (r_y),
            .right_key   (r_key),
            .behind      (c_behind[i]),
            .x           (c_x[i]),
            .y           (c_y[i]),
            .key         (c_key[i])
        );
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OCC_BITS'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        go && (kc_op == dspq_pkg::OP_INSERT) && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not add an entry");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> rsp_valid_reg && (occ_reg == count_reg))
        else $error("reported occupancy differs from entry count");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= OCC_BITS'(2)) |-> (c_key[0] <= c_key[1]))
        else $error("head key above second key");
`endif

endmodule

`default_nettype wire

[dv/dspq_checker.sv]
// ----------------------------------------------------------------------------
// dspq_checker
// Follows goal writes and accepted requests, keeps its own sorted open list,
// and compares every response beat field by field against the oldest
// prediction still owed.
// ----------------------------------------------------------------------------
module dspq_checker #(
    parameter int QUEUE_DEPTH = 64,
    parameter int COORD_BITS  = 10
) (
    input  logic clk,
    input  logic rst_n,
    dspq_req_if  req,
    dspq_rsp_if  rsp,
    dspq_cfg_if  cfg,
    output int   error_count,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import dspq_pkg::*;

    localparam int KEY_BITS = 2 * COORD_BITS + 1;
    localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [KEY_BITS-1:0]   dist_t;

    typedef struct packed {
        status_t             status;
        coord_t              head_x;
        coord_t              head_y;
        dist_t               head_key;
        logic [OCC_BITS-1:0] occupancy;
    } queue_answer_t;

    coord_t        goal_x;
    coord_t        goal_y;
    coord_t        open_x [QUEUE_DEPTH];
    coord_t        open_y [QUEUE_DEPTH];
    dist_t         open_key [QUEUE_DEPTH];
    int            open_count;
    queue_answer_t owed_answers [$];

    function automatic dist_t distance_sq(coord_t x, coord_t y);
        dist_t dx;
        dist_t dy;
        dx = (x >= goal_x) ? dist_t'(x - goal_x) : dist_t'(goal_x - x);
        dy = (y >= goal_y) ? dist_t'(y - goal_y) : dist_t'(goal_y - y);
        return dx * dx + dy * dy;
    endfunction

    // Apply one request to the open list and return the response it owes.
    function automatic queue_answer_t advance_open_list(opcode_t op, coord_t x, coord_t y);
        queue_answer_t answer;
        dist_t         key;
        int            slot;
        int            i;
        answer = '0;
        answer.status = ST_DONE;
        case (op)
            OP_INSERT:
            begin
                if (open_count >= QUEUE_DEPTH)
                begin
                    answer.status = ST_FULL;
                end
                else
                begin
                    key = distance_sq(x, y);
                    // land ahead of every entry with an equal or larger key
                    slot = 0;
                    while (slot < open_count && open_key[slot] < key)
                        slot++;
                    for (i = open_count; i > slot; i--)
                    begin
                        open_x[i]   = open_x[i-1];
                        open_y[i]   = open_y[i-1];
                        open_key[i] = open_key[i-1];
                    end
                    open_x[slot]   = x;
                    open_y[slot]   = y;
                    open_key[slot] = key;
                    open_count++;
                end
            end
            OP_POP:
            begin
                if (open_count == 0)
                begin
                    answer.status = ST_EMPTY;
                end
                else
                begin
                    answer.head_x   = open_x[0];
                    answer.head_y   = open_y[0];
                    answer.head_key = open_key[0];
                    for (i = 1; i < open_count; i++)
                    begin
                        open_x[i-1]   = open_x[i];
                        open_y[i-1]   = open_y[i];
                        open_key[i-1] = open_key[i];
                    end
                    open_count--;
                end
            end
            OP_CLEAR:
            begin
                open_count = 0;
            end
            default:
            begin
            end
        endcase
        answer.occupancy = OCC_BITS'(open_count);
        return answer;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_answer_t want;
        if (!rst_n)
        begin
            goal_x      = '0;
            goal_y      = '0;
            open_count  = 0;
            error_count = 0;
            outstanding = 0;
            owed_answers.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (owed_answers.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    error_count++;
                end
                else
                begin
                    want = owed_answers.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("head_x", want.head_x, rsp.head_x);
                    check_field("head_y", want.head_y, rsp.head_y);
                    check_field("head_key", want.head_key, rsp.head_key);
                    check_field("occupancy", want.occupancy, rsp.occupancy);
                end
            end
            if (req.valid && req.ready)
                owed_answers.push_back(advance_open_list(opcode_t'(req.opcode),
                                                         req.cell_x, req.cell_y));
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_GOAL_X)
                    goal_x = cfg.data;
                else if (cfg.index == REG_GOAL_Y)
                    goal_y = cfg.data;
            end
            outstanding = owed_answers.size();
        end
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the distance-sorted priority queue with a directed opening and
// random insert, pop, clear and no-op traffic under several goal cells, with
// bursty requests and a stalling response side; the checker judges the beats.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dspq_pkg::*;

    localparam int QUEUE_DEPTH    = 64;
    localparam int COORD_BITS     = 10;
    localparam int OCC_BITS       = $clog2(QUEUE_DEPTH + 1);
    localparam int RANDOM_ITEMS   = 1900;
    localparam int NUM_PHASES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_PERIODIC,
        SINK_BLOCKS
    } sink_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   error_count;
    int   outstanding;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dspq_req_if #(.COORD_BITS(COORD_BITS))                     req ();
    dspq_rsp_if #(.COORD_BITS(COORD_BITS), .OCC_BITS(OCC_BITS)) rsp ();
    dspq_cfg_if #(.COORD_BITS(COORD_BITS))                     cfg ();

    distance_sorted_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .rsp  (rsp),
        .cfg  (cfg)
    );

    dspq_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .error_count(error_count),
        .outstanding(outstanding)
    );

    // ------------------------------------------------------------------
    // Response side: stall in modes that are picked at random and change
    // ------------------------------------------------------------------
    sink_mode_t sink_mode   = SINK_OPEN;
    int         mode_left   = 0;
    int         sink_period = 4;
    int         sink_tick   = 0;
    int         block_left  = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            sink_mode   <= sink_mode_t'($urandom_range(0, 3));
            mode_left   <= $urandom_range(30, 250);
            sink_period <= $urandom_range(2, 16);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        sink_tick <= sink_tick + 1;
        case (sink_mode)
            SINK_OPEN:     rsp.ready <= 1'b1;
            SINK_COIN:     rsp.ready <= ($urandom_range(0, 3) != 0);
            SINK_PERIODIC: rsp.ready <= (sink_tick % sink_period) >= (sink_period / 2);
            default:
            begin
                if (block_left == 0)
                begin
                    rsp.ready  <= ~rsp.ready;
                    block_left <= $urandom_range(1, 16);
                end
                else
                begin
                    block_left <= block_left - 1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int     burst_left = 0;
    coord_t cur_gx     = '0;
    coord_t cur_gy     = '0;
    coord_t last_x     = '0;
    coord_t last_y     = '0;

    // Hold the beat until accepted; gap whenever a burst runs out.
    task automatic send_item(opcode_t op, coord_t x, coord_t y);
        bit took;
        req.valid  <= 1'b1;
        req.opcode <= op;
        req.cell_x <= x;
        req.cell_y <= y;
        do
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
        while (!took);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    // Leaves cfg.valid high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, coord_t value);
        bit took;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
        begin
            @(negedge clk);
            took = cfg.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic set_goal(coord_t gx, coord_t gy, bit poke_unmapped);
        if (poke_unmapped)
            write_reg(REG_UNMAPPED, coord_t'($urandom));
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        cfg.valid <= 1'b0;
        cur_gx = gx;
        cur_gy = gy;
    endtask

    function automatic coord_t pick_coord(coord_t center);
        coord_t c;
        case ($urandom_range(0, 9))
            0:       c = '0;
            1:       c = '1;
            2, 3:    c = center + coord_t'($urandom_range(0, 8)) - coord_t'(4);
            default: c = coord_t'($urandom);
        endcase
        return c;
    endfunction

    initial
    begin
        int     phase;
        int     n;
        int     r;
        int     stretch_left;
        int     insert_pct;
        int     insert_share [4];
        coord_t gx;
        coord_t gy;
        coord_t x;
        coord_t y;

        insert_share = '{90, 70, 48, 20};
        req.valid  <= 1'b0;
        req.opcode <= OP_NOP;
        req.cell_x <= '0;
        req.cell_y <= '0;
        cfg.valid  <= 1'b0;
        cfg.index  <= REG_GOAL_X;
        cfg.data   <= '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening with the reset goal at the origin.
        send_item(OP_POP, '0, '0);
        send_item(OP_NOP, '1, '1);
        send_item(OP_INSERT, '1, '1);
        send_item(OP_INSERT, '0, '0);
        send_item(OP_INSERT, 10'd3, 10'd4);
        send_item(OP_INSERT, 10'd4, 10'd3);
        send_item(OP_INSERT, 10'd5, 10'd0);
        send_item(OP_INSERT, '1, '0);
        send_item(OP_INSERT, '0, '1);
        repeat (7) send_item(OP_POP, '1, '1);
        send_item(OP_POP, '0, '0);
        send_item(OP_INSERT, 10'd7, 10'd7);
        send_item(OP_INSERT, 10'd2, 10'd9);
        send_item(OP_CLEAR, '1, '1);
        send_item(OP_POP, '0, '0);
        send_item(OP_NOP, '0, '0);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0:       begin gx = '1;            gy = '1;            end
                1:       begin gx = '0;            gy = '1;            end
                2:       begin gx = '1;            gy = '0;            end
                3:       begin gx = 10'd512;       gy = 10'd511;       end
                4:       begin gx = '0;            gy = '0;            end
                default: begin gx = coord_t'($urandom); gy = coord_t'($urandom); end
            endcase
            set_goal(gx, gy, phase == 0);

            // open each phase insert-heavy so the list reaches full
            insert_pct   = insert_share[0];
            stretch_left = $urandom_range(80, 120);
            for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
            begin
                if (stretch_left == 0)
                begin
                    insert_pct   = insert_share[$urandom_range(0, 3)];
                    stretch_left = $urandom_range(20, 120);
                end
                else
                begin
                    stretch_left--;
                end
                r = $urandom_range(0, 99);
                if (r < 1)
                begin
                    send_item(OP_CLEAR, coord_t'($urandom), coord_t'($urandom));
                end
                else if (r < 3)
                begin
                    send_item(OP_NOP, coord_t'($urandom), coord_t'($urandom));
                end
                else if (r < 3 + insert_pct)
                begin
                    // mirror or swap the last cell around the goal to force equal keys
                    if ($urandom_range(0, 4) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            x = coord_t'(2 * cur_gx) - last_x;
                            y = coord_t'(2 * cur_gy) - last_y;
                        end
                        else
                        begin
                            x = cur_gx + last_y - cur_gy;
                            y = cur_gy + last_x - cur_gx;
                        end
                    end
                    else
                    begin
                        x = pick_coord(cur_gx);
                        y = pick_coord(cur_gy);
                    end
                    last_x = x;
                    last_y = y;
                    send_item(OP_INSERT, x, y);
                end
                else
                begin
                    send_item(OP_POP, coord_t'($urandom), coord_t'($urandom));
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[sim.f]
rtl/dspq_pkg.sv
rtl/dspq_if.sv
rtl/dspq_key_calc.sv
rtl/dspq_cell.sv
rtl/distance_sorted_priority_queue_top.sv
dv/dspq_checker.sv
dv/testbench.sv
